### hw/rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a property outside of reset
`define VT_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: assertion failed");

// check a property on every clock edge, reset included
`define VT_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("%m: assertion failed");

`endif

### hw/rtl/vt52c_pkg.sv
`timescale 1ns / 1ps
package vt52c_pkg;

  localparam int COLUMNS_DEF = 64;
  localparam int ROWS_DEF    = 32;

  typedef logic [1:0] job_t;
  localparam job_t JOB_NONE  = 2'd0;
  localparam job_t JOB_SHIFT = 2'd1;
  localparam job_t JOB_CLEAR = 2'd2;

  typedef struct packed {
    logic ld_item;
    logic decode;
    logic fin;
    logic sh_rd;
    logic sh_wr;
    logic ld_clr;
    logic clr_wr;
    logic step;
  } cmd_t;

  typedef struct packed {
    job_t job;
    logic sw_last;
    logic out_busy;
  } sts_t;

endpackage

### hw/rtl/vt52c_if.sv
`timescale 1ns / 1ps
interface vt52c_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] char_code;
  logic [4:0] read_row;
  logic [5:0] read_col;

  modport source (output valid, kind, char_code, read_row, read_col, input ready);
  modport sink   (input valid, kind, char_code, read_row, read_col, output ready);
endinterface

interface vt52c_out_if;
  logic       valid;
  logic       ready;
  logic [4:0] cursor_row;
  logic [5:0] cursor_col;
  logic [6:0] cell_code;
  logic [1:0] escape_state;

  modport source (output valid, cursor_row, cursor_col, cell_code, escape_state,
                  input ready);
  modport sink   (input valid, cursor_row, cursor_col, cell_code, escape_state,
                  output ready);
endinterface

### hw/rtl/vt52_text_console.sv
`timescale 1ns / 1ps
// channel  | dir | handshake   | word
// in_ch    | in  | valid/ready | kind, char_code, read_row, read_col
// out_ch   | out | valid/ready | cursor_row, cursor_col, cell_code, escape_state
//
// After reset all ROWS*COLUMNS cells (2048 by default) of the cell store are
// cleared, one cell a cycle; in_ch.ready stays low meanwhile.
// A word is loaded and decoded; a backspace or scroll then reads and writes
// each cell it moves in turn and loads the clear, while an erase goes straight
// to the clear; cells are cleared one a cycle, then the result is registered.
// One word is in flight; a stalled out_ch holds in_ch off.
module vt52_text_console #(
  parameter int COLUMNS = vt52c_pkg::COLUMNS_DEF,
  parameter int ROWS    = vt52c_pkg::ROWS_DEF
) (
  input logic        clk,
  input logic        rst_n,
  vt52c_in_if.sink   in_ch,
  vt52c_out_if.source out_ch
);

  vt52c_pkg::cmd_t cmd;
  vt52c_pkg::sts_t sts;

  vt52c_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  vt52c_dp #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_kind          (in_ch.kind),
    .in_char_code     (in_ch.char_code),
    .in_read_row      (in_ch.read_row),
    .in_read_col      (in_ch.read_col),
    .out_ready        (out_ch.ready),
    .out_valid        (out_ch.valid),
    .out_cursor_row   (out_ch.cursor_row),
    .out_cursor_col   (out_ch.cursor_col),
    .out_cell_code    (out_ch.cell_code),
    .out_escape_state (out_ch.escape_state),
    .cmd              (cmd),
    .sts              (sts)
  );

endmodule

### hw/rtl/vt52c_ctrl.sv
`timescale 1ns / 1ps
module vt52c_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  vt52c_pkg::sts_t  sts,
  output vt52c_pkg::cmd_t  cmd
);

  localparam logic [2:0] S_INIT  = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_DEC   = 3'd2;
  localparam logic [2:0] S_SHRD  = 3'd3;
  localparam logic [2:0] S_SHWR  = 3'd4;
  localparam logic [2:0] S_LDCLR = 3'd5;
  localparam logic [2:0] S_CLR   = 3'd6;
  localparam logic [2:0] S_FIN   = 3'd7;

  logic [2:0] state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_INIT: begin
        cmd.clr_wr = 1'b1;
        if (sts.sw_last) begin
          state_nxt = S_IDLE;
        end else begin
          cmd.step = 1'b1;
        end
      end
      S_IDLE: begin
        in_ready = !sts.out_busy;
        if (in_valid && !sts.out_busy) begin
          cmd.ld_item = 1'b1;
          state_nxt   = S_DEC;
        end
      end
      S_DEC: begin
        cmd.decode = 1'b1;
        case (sts.job)
          vt52c_pkg::JOB_SHIFT: state_nxt = S_SHRD;
          vt52c_pkg::JOB_CLEAR: state_nxt = S_CLR;
          default:              state_nxt = S_FIN;
        endcase
      end
      S_SHRD: begin
        cmd.sh_rd = 1'b1;
        state_nxt = S_SHWR;
      end
      S_SHWR: begin
        cmd.sh_wr = 1'b1;
        if (sts.sw_last) begin
          state_nxt = S_LDCLR;
        end else begin
          cmd.step  = 1'b1;
          state_nxt = S_SHRD;
        end
      end
      S_LDCLR: begin
        cmd.ld_clr = 1'b1;
        state_nxt  = S_CLR;
      end
      S_CLR: begin
        cmd.clr_wr = 1'b1;
        if (sts.sw_last) begin
          state_nxt = S_FIN;
        end else begin
          cmd.step = 1'b1;
        end
      end
      S_FIN: begin
        cmd.fin   = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_INIT;
    endcase
  end

endmodule

### hw/rtl/vt52c_dp.sv
`timescale 1ns / 1ps
module vt52c_dp #(
  parameter int COLUMNS = vt52c_pkg::COLUMNS_DEF,
  parameter int ROWS    = vt52c_pkg::ROWS_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_kind,
  input  logic [7:0]      in_char_code,
  input  logic [4:0]      in_read_row,
  input  logic [5:0]      in_read_col,
  input  logic            out_ready,
  output logic            out_valid,
  output logic [4:0]      out_cursor_row,
  output logic [5:0]      out_cursor_col,
  output logic [6:0]      out_cell_code,
  output logic [1:0]      out_escape_state,
  input  vt52c_pkg::cmd_t cmd,
  output vt52c_pkg::sts_t sts
);

  localparam int RW    = $clog2(ROWS);
  localparam int CW    = $clog2(COLUMNS);
  localparam int AW    = RW + CW;
  localparam int DEPTH = 1 << AW;
  localparam logic [RW-1:0] ROW_LAST = RW'(ROWS - 1);
  localparam logic [RW-1:0] ROW_PEN  = RW'(ROWS - 2);
  localparam logic [CW-1:0] COL_LAST = CW'(COLUMNS - 1);
  localparam logic [CW-1:0] COL_PEN  = CW'(COLUMNS - 2);

  localparam logic [1:0] ESC_IDLE = 2'd0;
  localparam logic [1:0] ESC_SEEN = 2'd1;
  localparam logic [1:0] ESC_ROW  = 2'd2;
  localparam logic [1:0] ESC_COL  = 2'd3;

  localparam logic [6:0] CH_SPACE = 7'h20;
  localparam logic [6:0] CH_ESC   = 7'h1b;
  localparam logic [6:0] CH_BEL   = 7'h07;
  localparam logic [6:0] CH_BS    = 7'h08;
  localparam logic [6:0] CH_TAB   = 7'h09;
  localparam logic [6:0] CH_LF    = 7'h0a;
  localparam logic [6:0] CH_CR    = 7'h0d;
  localparam logic [6:0] CH_DEL   = 7'h7f;
  localparam logic [6:0] CH_UP    = 7'h41;
  localparam logic [6:0] CH_DOWN  = 7'h42;
  localparam logic [6:0] CH_RIGHT = 7'h43;
  localparam logic [6:0] CH_LEFT  = 7'h44;
  localparam logic [6:0] CH_HOME  = 7'h48;
  localparam logic [6:0] CH_ERSCR = 7'h4a;
  localparam logic [6:0] CH_ERLIN = 7'h4b;
  localparam logic [6:0] CH_ADDR  = 7'h59;

  logic [6:0]    mem [DEPTH];
  logic [6:0]    rdata_r;

  logic          kind_r;
  logic [6:0]    code_r;
  logic [4:0]    rr_r;
  logic [5:0]    rc_r;

  logic [RW-1:0] cur_row_r;
  logic [CW-1:0] cur_col_r;
  logic [1:0]    esc_r;

  logic [RW-1:0] sw_row_r, sw_end_row_r, cl_row_r, cl_end_row_r;
  logic [CW-1:0] sw_col_r, sw_end_col_r, cl_col_r;
  logic          sw_vert_r;

  logic          out_valid_r;
  logic [4:0]    o_row_r;
  logic [5:0]    o_col_r;
  logic [6:0]    o_cell_r;
  logic [1:0]    o_esc_r;

  // decode results
  logic [RW-1:0] nrow, sh_row, sh_end_row, cl_row, cl_end_row;
  logic [CW-1:0] ncol, sh_col, sh_end_col, cl_col;
  logic [1:0]    nesc;
  logic          wr_char, sh_vert;
  vt52c_pkg::job_t job;
  logic [7:0]    coord;
  logic [CW:0]   tab_col;
  logic          rd_in_range;

  logic [AW-1:0] waddr, raddr;
  logic [6:0]    wdata;
  logic          we;

  always_comb begin
    nrow       = cur_row_r;
    ncol       = cur_col_r;
    nesc       = esc_r;
    wr_char    = 1'b0;
    job        = vt52c_pkg::JOB_NONE;
    sh_vert    = 1'b0;
    sh_row     = cur_row_r;
    sh_col     = cur_col_r;
    sh_end_row = cur_row_r;
    sh_end_col = COL_PEN;
    cl_row     = cur_row_r;
    cl_col     = cur_col_r;
    cl_end_row = cur_row_r;
    coord      = {1'b0, code_r} - 8'h20;
    tab_col    = {1'b0, cur_col_r & ~CW'(7)} + (CW+1)'(8);
    if (!kind_r) begin
      unique case (esc_r)
        ESC_ROW: begin
          nrow = (coord >= ROWS) ? ROW_LAST : RW'(coord);
          nesc = ESC_COL;
        end
        ESC_COL: begin
          ncol = (coord >= COLUMNS) ? COL_LAST : CW'(coord);
          nesc = ESC_IDLE;
        end
        ESC_SEEN: begin
          nesc = ESC_IDLE;
          case (code_r)
            CH_ADDR:  nesc = ESC_ROW;
            CH_UP:    if (cur_row_r != '0) nrow = cur_row_r - 1'b1;
            CH_DOWN:  if (cur_row_r != ROW_LAST) nrow = cur_row_r + 1'b1;
            CH_RIGHT: if (cur_col_r != COL_LAST) ncol = cur_col_r + 1'b1;
            CH_LEFT:  if (cur_col_r != '0) ncol = cur_col_r - 1'b1;
            CH_HOME: begin
              nrow = '0;
              ncol = '0;
            end
            CH_ERSCR: begin
              job        = vt52c_pkg::JOB_CLEAR;
              cl_end_row = ROW_LAST;
            end
            CH_ERLIN: job = vt52c_pkg::JOB_CLEAR;
            default: ;
          endcase
        end
        default: begin
          if (code_r == CH_BEL) begin
          end else if (code_r == CH_BS) begin
            job    = vt52c_pkg::JOB_SHIFT;
            sh_col = (cur_col_r == '0) ? '0 : cur_col_r - 1'b1;
            cl_col = COL_LAST;
            if (cur_col_r != '0) begin
              ncol = cur_col_r - 1'b1;
            end else if (cur_row_r != '0) begin
              nrow = cur_row_r - 1'b1;
              ncol = COL_LAST;
            end
          end else if (code_r == CH_TAB) begin
            ncol = (tab_col >= COLUMNS) ? COL_LAST : tab_col[CW-1:0];
          end else if (code_r == CH_CR) begin
            ncol = '0;
          end else if (code_r == CH_ESC) begin
            nesc = ESC_SEEN;
          end else if (code_r == CH_LF || (code_r >= CH_SPACE && code_r != CH_DEL)) begin
            wr_char = (code_r != CH_LF);
            if (code_r != CH_LF && cur_col_r != COL_LAST) begin
              ncol = cur_col_r + 1'b1;
            end else begin
              ncol = '0;
              if (cur_row_r == ROW_LAST) begin
                job        = vt52c_pkg::JOB_SHIFT;
                sh_vert    = 1'b1;
                sh_row     = '0;
                sh_col     = '0;
                sh_end_row = ROW_PEN;
                sh_end_col = COL_LAST;
                cl_row     = ROW_LAST;
                cl_col     = '0;
                cl_end_row = ROW_LAST;
              end else begin
                nrow = cur_row_r + 1'b1;
              end
            end
          end
        end
      endcase
    end
  end

  assign rd_in_range = (int'(rr_r) < ROWS) && (int'(rc_r) < COLUMNS);

  always_comb begin
    we    = 1'b0;
    waddr = {sw_row_r, sw_col_r};
    wdata = '0;
    if (cmd.decode && wr_char) begin
      we    = 1'b1;
      waddr = {cur_row_r, cur_col_r};
      wdata = code_r;
    end else if (cmd.sh_wr) begin
      we    = 1'b1;
      wdata = rdata_r;
    end else if (cmd.clr_wr) begin
      we    = 1'b1;
    end
    if (cmd.sh_rd) begin
      raddr = sw_vert_r ? {sw_row_r + 1'b1, sw_col_r} : {sw_row_r, sw_col_r + 1'b1};
    end else begin
      raddr = {RW'(rr_r), CW'(rc_r)};
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_item) begin
      kind_r <= in_kind;
      code_r <= in_char_code[6:0];
      rr_r   <= in_read_row;
      rc_r   <= in_read_col;
    end
    if (cmd.decode) begin
      cl_row_r     <= cl_row;
      cl_col_r     <= cl_col;
      cl_end_row_r <= cl_end_row;
    end
    if (cmd.fin) begin
      o_row_r  <= 5'(cur_row_r);
      o_col_r  <= 6'(cur_col_r);
      o_cell_r <= (kind_r && rd_in_range) ? rdata_r : '0;
      o_esc_r  <= esc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_row_r    <= '0;
      cur_col_r    <= '0;
      esc_r        <= ESC_IDLE;
      out_valid_r  <= 1'b0;
      sw_row_r     <= '0;
      sw_col_r     <= '0;
      sw_end_row_r <= ROW_LAST;
      sw_end_col_r <= COL_LAST;
      sw_vert_r    <= 1'b0;
    end else begin
      if (cmd.fin) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cmd.decode) begin
        cur_row_r <= nrow;
        cur_col_r <= ncol;
        esc_r     <= nesc;
        if (job == vt52c_pkg::JOB_SHIFT) begin
          sw_row_r     <= sh_row;
          sw_col_r     <= sh_col;
          sw_end_row_r <= sh_end_row;
          sw_end_col_r <= sh_end_col;
          sw_vert_r    <= sh_vert;
        end else begin
          sw_row_r     <= cl_row;
          sw_col_r     <= cl_col;
          sw_end_row_r <= cl_end_row;
          sw_end_col_r <= COL_LAST;
        end
      end else if (cmd.ld_clr) begin
        sw_row_r     <= cl_row_r;
        sw_col_r     <= cl_col_r;
        sw_end_row_r <= cl_end_row_r;
        sw_end_col_r <= COL_LAST;
      end else if (cmd.step) begin
        if (sw_col_r == COL_LAST) begin
          sw_col_r <= '0;
          sw_row_r <= sw_row_r + 1'b1;
        end else begin
          sw_col_r <= sw_col_r + 1'b1;
        end
      end
    end
  end

  assign sts.job      = job;
  assign sts.sw_last  = (sw_row_r == sw_end_row_r) && (sw_col_r == sw_end_col_r);
  assign sts.out_busy = out_valid_r;

  assign out_valid        = out_valid_r;
  assign out_cursor_row   = o_row_r;
  assign out_cursor_col   = o_col_r;
  assign out_cell_code    = o_cell_r;
  assign out_escape_state = o_esc_r;

endmodule

### hw/rtl/vt52c_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module vt52c_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [4:0] out_cursor_row,
  input logic [5:0] out_cursor_col,
  input logic [6:0] out_cell_code,
  input logic [1:0] out_escape_state
);

  logic [19:0] out_word;

  assign out_word = {out_cursor_row, out_cursor_col, out_cell_code, out_escape_state};

  `VT_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid)
  `VT_ASSERT(a_out_stable, out_valid && !out_ready |=> $stable(out_word))
  `VT_ASSERT(a_one_in_flight, out_valid |-> !in_ready)
  `VT_ASSERT(a_no_same_cycle, in_valid && in_ready |=> !out_valid)
  `VT_ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> !out_valid && !in_ready)

endmodule

bind vt52_text_console vt52c_checker u_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_cursor_row   (out_ch.cursor_row),
  .out_cursor_col   (out_ch.cursor_col),
  .out_cell_code    (out_ch.cell_code),
  .out_escape_state (out_ch.escape_state)
);

### sim/vt52_text_console_tb.sv
`timescale 1ns / 1ps
module vt52_text_console_tb;
  localparam int COLS = vt52c_pkg::COLUMNS_DEF;
  localparam int ROWN = vt52c_pkg::ROWS_DEF;
  localparam int CYCLE_LIMIT = 30000000;

  typedef struct packed {
    logic       kind;
    logic [7:0] char_code;
    logic [4:0] read_row;
    logic [5:0] read_col;
  } term_word_t;

  typedef struct packed {
    logic [4:0] cursor_row;
    logic [5:0] cursor_col;
    logic [6:0] cell_code;
    logic [1:0] escape_state;
  } screen_word_t;

  localparam logic [6:0] CH_BEL = 7'h07;
  localparam logic [6:0] CH_BS  = 7'h08;
  localparam logic [6:0] CH_TAB = 7'h09;
  localparam logic [6:0] CH_LF  = 7'h0a;
  localparam logic [6:0] CH_CR  = 7'h0d;
  localparam logic [6:0] CH_ESC = 7'h1b;
  localparam logic [6:0] CH_DEL = 7'h7f;

  logic clk;
  logic rst_n;
  vt52c_in_if  in_ch();
  vt52c_out_if out_ch();

  vt52_text_console u_dut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));

  logic [6:0] cells [ROWN*COLS];
  int crow, ccol, ephase;

  term_word_t   pending_words [$];
  screen_word_t expected_words [$];
  int mismatches;
  int cycles;
  int gap_left;
  int stall_left;
  bit hold_off;

  function automatic void clear_span(int r, int from);
    for (int j = from; j < COLS; j++) cells[r*COLS+j] = 7'd0;
  endfunction

  function automatic void new_line(inout int r, inout int c);
    if (r >= ROWN-1) begin
      for (int i = 0; i < (ROWN-1)*COLS; i++) cells[i] = cells[i+COLS];
      clear_span(ROWN-1, 0);
      r = ROWN-1;
    end else begin
      r = r + 1;
    end
    c = 0;
  endfunction

  function automatic void feed_char(logic [6:0] ch);
    int r, c, v;
    r = crow;
    c = ccol;
    if (ephase == 2) begin
      v = (int'(ch) - 32) & 255;
      r = (v >= ROWN) ? ROWN-1 : v;
      ephase = 3;
    end else if (ephase == 3) begin
      v = (int'(ch) - 32) & 255;
      c = (v >= COLS) ? COLS-1 : v;
      ephase = 0;
    end else if (ephase == 1) begin
      ephase = 0;
      case (ch)
        "Y": ephase = 2;
        "A": if (r > 0) r--;
        "B": if (r < ROWN-1) r++;
        "C": if (c < COLS-1) c++;
        "D": if (c > 0) c--;
        "H": begin r = 0; c = 0; end
        "J": begin
          clear_span(r, c);
          for (int k = r+1; k < ROWN; k++) clear_span(k, 0);
        end
        "K": clear_span(r, c);
        default: ;
      endcase
    end else if (ch == CH_BEL) begin
      return;
    end else if (ch == CH_BS) begin
      for (int i = (c == 0) ? 1 : c; i < COLS; i++) cells[r*COLS+i-1] = cells[r*COLS+i];
      cells[r*COLS+COLS-1] = 7'd0;
      if (c > 0) c--;
      else if (r > 0) begin r--; c = COLS-1; end
    end else if (ch == CH_TAB) begin
      c = (c & 'hf8) + 8;
      if (c >= COLS) c = COLS-1;
    end else if (ch == CH_LF) begin
      new_line(r, c);
    end else if (ch == CH_CR) begin
      c = 0;
    end else if (ch == CH_ESC) begin
      ephase = 1;
    end else if (ch < 7'h20 || ch == CH_DEL) begin
      return;
    end else begin
      cells[r*COLS+c] = ch;
      if (c >= COLS-1) new_line(r, c);
      else c++;
    end
    crow = r;
    ccol = c;
  endfunction

  function automatic screen_word_t predict_screen(term_word_t w);
    screen_word_t e;
    logic [6:0] cell_val;
    cell_val = 7'd0;
    if (!w.kind) feed_char(w.char_code[6:0]);
    else if (w.read_row < ROWN && w.read_col < COLS)
      cell_val = cells[w.read_row*COLS + w.read_col];
    e.cursor_row = crow[4:0];
    e.cursor_col = ccol[5:0];
    e.cell_code = cell_val;
    e.escape_state = ephase[1:0];
    return e;
  endfunction

  task automatic push_word(logic k, logic [7:0] ch, logic [4:0] rr, logic [5:0] rc);
    term_word_t w;
    w.kind = k;
    w.char_code = ch;
    w.read_row = rr;
    w.read_col = rc;
    pending_words.push_back(w);
  endtask

  task automatic push_char(logic [7:0] ch);
    push_word(1'b0, ch, 5'($urandom), 6'($urandom));
  endtask

  task automatic push_read();
    push_word(1'b1, 8'($urandom), 5'($urandom), 6'($urandom));
  endtask

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d want %0d at cycle %0d", what, got, want, cycles);
    mismatches++;
  endtask

  function automatic int pick_gap();
    if ($urandom_range(0, 3) == 0) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
    return $urandom_range(0, 3);
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst_n = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      gap_left <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        expected_words.push_back(predict_screen(term_word_t'({in_ch.kind, in_ch.char_code,
                                                             in_ch.read_row, in_ch.read_col})));
        void'(pending_words.pop_front());
      end
      if (in_ch.valid && !in_ch.ready) begin
      end else if (gap_left > 0) begin
        in_ch.valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (hold_off && (expected_words.size() != 0 || (in_ch.valid && in_ch.ready))) begin
        in_ch.valid <= 1'b0;
      end else if (pending_words.size() > 0) begin
        term_word_t w;
        w = pending_words[0];
        in_ch.valid <= 1'b1;
        {in_ch.kind, in_ch.char_code, in_ch.read_row, in_ch.read_col} <= w;
        gap_left <= pick_gap();
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_words.size() == 0) begin
          report_mismatch("unexpected word", 0, 0);
        end else begin
          screen_word_t e;
          e = expected_words.pop_front();
          if (out_ch.cursor_row !== e.cursor_row)
            report_mismatch("cursor_row", out_ch.cursor_row, e.cursor_row);
          if (out_ch.cursor_col !== e.cursor_col)
            report_mismatch("cursor_col", out_ch.cursor_col, e.cursor_col);
          if (out_ch.cell_code !== e.cell_code)
            report_mismatch("cell_code", out_ch.cell_code, e.cell_code);
          if (out_ch.escape_state !== e.escape_state)
            report_mismatch("escape_state", out_ch.escape_state, e.escape_state);
        end
      end
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left <= stall_left - 1;
      end else begin
        out_ch.ready <= 1'b1;
        stall_left <= pick_gap();
      end
    end
  end

  initial begin
    logic [7:0] ch;
    int n;
    in_ch.valid = 1'b0;
    in_ch.kind = 1'b0;
    in_ch.char_code = 8'd0;
    in_ch.read_row = 5'd0;
    in_ch.read_col = 6'd0;
    out_ch.ready = 1'b0;
    mismatches = 0;
    cycles = 0;
    hold_off = 1'b0;
    for (int i = 0; i < ROWN*COLS; i++) cells[i] = 7'd0;
    crow = 0;
    ccol = 0;
    ephase = 0;

    push_char(8'h08);
    push_char("A");
    push_char(8'hc1);
    push_word(1'b1, 8'hff, 5'd31, 6'd63);
    push_word(1'b1, 8'h00, 5'd0, 6'd0);
    push_char(8'h1b); push_char("D");
    push_char(8'h1b); push_char("A");
    push_char(8'h1b); push_char("Y"); push_char(8'h7f); push_char(8'h10);
    push_char(8'h7e);
    push_char(8'h1b); push_char("C");
    push_char(8'h09); push_char(8'h0a); push_char(8'h0d); push_char(8'h07);
    push_char(8'h1b); push_char("B");
    push_char(8'h1b); push_char("Q");
    push_char(8'h1b); push_char("J");
    push_char(8'h1b); push_char("H");
    push_word(1'b1, 8'h00, 5'd0, 6'd0);

    wait (pending_words.size() == 0 && expected_words.size() == 0);
    hold_off = 1'b1;
    repeat (20) @(posedge clk);
    hold_off = 1'b0;

    for (n = 0; n < 1250; ) begin
      @(posedge clk);
      while (pending_words.size() > 8) @(posedge clk);
      case ($urandom_range(0, 9))
        0, 1, 2: begin push_char(8'($urandom_range(32, 126)) | 8'($urandom_range(0, 1) << 7)); n++; end
        3: begin push_read(); n++; end
        4: begin
          push_char(8'h1b); push_char("Y");
          push_char(8'($urandom_range(0, 255))); push_char(8'($urandom_range(0, 255)));
          n += 4;
        end
        5: begin
          case ($urandom_range(0, 7))
            0: ch = "A"; 1: ch = "B"; 2: ch = "C"; 3: ch = "D";
            4: ch = "H"; 5: ch = ($urandom_range(0, 7) == 0) ? "J" : "K";
            6: ch = "Y";
            default: ch = 8'($urandom);
          endcase
          push_char(8'h1b); push_char(ch); n += 2;
        end
        6: begin
          case ($urandom_range(0, 5))
            0: ch = 8'h08; 1: ch = 8'h09; 2: ch = 8'h0a;
            3: ch = 8'h0d; 4: ch = 8'h07; default: ch = 8'($urandom_range(0, 31));
          endcase
          push_char(ch | 8'($urandom_range(0, 1) << 7)); n++;
        end
        7: begin push_char(8'($urandom)); n++; end
        default: begin
          push_word(1'b1, 8'($urandom), 5'(crow), 6'($urandom)); n++;
        end
      endcase
    end

    wait (pending_words.size() == 0 && expected_words.size() == 0);
    repeat (5000) @(posedge clk);
    if (mismatches == 0 && expected_words.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule

### sim.f
+incdir+hw/rtl
hw/rtl/vt52c_pkg.sv
hw/rtl/vt52c_if.sv
hw/rtl/vt52c_ctrl.sv
hw/rtl/vt52c_dp.sv
hw/rtl/vt52_text_console.sv
hw/rtl/vt52c_checker.sv
sim/vt52_text_console_tb.sv
